### src/lpf_sieve_factorizer_defines.svh
// assertion macros shared by the sieve factorizer rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef LPF_SIEVE_FACTORIZER_DEFINES_SVH
`define LPF_SIEVE_FACTORIZER_DEFINES_SVH

// same-cycle implication checked at every clock edge out of reset
`define LSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked at every clock edge out of reset
`define LSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/lsf_pkg.sv
// types and constants for the least-prime-factor sieve factorizer
// no dependencies
package lsf_pkg;

    localparam int MAX_N       = 1048576;
    localparam int PRIME_SLOTS = 131072;
    localparam int MAX_FACTORS = 8;

    localparam int VAL_W   = 20;
    localparam int EXP_W   = 5;
    localparam int CNT_W   = 17;
    localparam int N_W     = $clog2(MAX_N);
    localparam int SLOT_W  = $clog2(PRIME_SLOTS);
    localparam int FILL_W  = $clog2(PRIME_SLOTS + 1);
    localparam int FACT_W  = $clog2(MAX_FACTORS + 1);
    localparam int PROD_W  = 2 * VAL_W;

    typedef enum logic
    {
        FUNC_BUILD     = 1'b0,
        FUNC_FACTORIZE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [0:0]       func;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed
    {
        logic [VAL_W-1:0] prime;
        logic [EXP_W-1:0] exponent;
        logic [CNT_W-1:0] prime_count;
        logic             error;
        logic             last;
    } result_t;

endpackage

### src/lpf_sieve_factorizer.sv
// Build clears entries 0..limit at one a cycle, then sieves each number in FREAD, FCHK,
// KREAD and each prime tried in KREAD, KMUL, KCHK; its one result is registered last.
// Factorize: each table read takes QREAD and QCHK, each division 20 bit steps and a check,
// exponent+1 divisions per factor; errors and values 0 and 1 answer the next cycle.
// Throughput: one transaction at a time, busy drops with the last result; no stalls.
// Reset: control state clears asynchronously, table is marked not built, limit = 1048575.
`include "lpf_sieve_factorizer_defines.svh"

module lpf_sieve_factorizer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [19:0]           cfg_wdata,
    input  logic                  start,
    input  lsf_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  result_valid,
    output lsf_pkg::result_t      result
);
    import lsf_pkg::*;

    localparam logic [VAL_W-1:0] LIM_MAX = VAL_W'(MAX_N - 1);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CLR,
        S_FREAD,
        S_FCHK,
        S_KREAD,
        S_KMUL,
        S_KCHK,
        S_QREAD,
        S_QCHK,
        S_DIV,
        S_DDONE
    } state_t;

    state_t              state_reg;
    logic [VAL_W-1:0]    limit_reg;
    logic [VAL_W-1:0]    lim_reg;
    logic [VAL_W-1:0]    built_reg;
    logic                ready_reg;
    logic [VAL_W-1:0]    i_reg;
    logic [VAL_W-1:0]    f_reg;
    logic [VAL_W-1:0]    q_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FILL_W-1:0]   cnt_reg;
    logic [FILL_W-1:0]   k_reg;
    logic [VAL_W-1:0]    x_reg;
    logic [VAL_W-1:0]    p_reg;
    logic [EXP_W-1:0]    e_reg;
    logic [FACT_W-1:0]   n_reg;
    logic [VAL_W:0]      rem_reg;
    logic [VAL_W-1:0]    quo_reg;
    logic [4:0]          dcnt_reg;
    logic                rvalid_reg;
    result_t             result_reg;

    // memories and their ports
    logic [VAL_W-1:0]    lpf_mem [MAX_N];
    logic [VAL_W-1:0]    plist_mem [PRIME_SLOTS];
    logic [VAL_W-1:0]    lpf_q_reg;
    logic [VAL_W-1:0]    pl_q_reg;
    logic                lpf_we;
    logic [N_W-1:0]      lpf_waddr;
    logic [VAL_W-1:0]    lpf_wdata;
    logic [N_W-1:0]      lpf_raddr;
    logic                pl_we;

    logic [VAL_W:0]      div_sh;
    logic                div_ge;
    logic [VAL_W-1:0]    lim_next;
    logic                kchk_stop;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    // divider step and compares
    assign div_sh    = {rem_reg[VAL_W-1:0], quo_reg[VAL_W-1]};
    assign div_ge    = (div_sh >= {1'b0, p_reg});
    assign lim_next  = (limit_reg > LIM_MAX) ? LIM_MAX : limit_reg;
    assign kchk_stop = (q_reg > f_reg) || (prod_reg > {{VAL_W{1'b0}}, lim_reg});

    // memory port steering
    always_comb
    begin
        lpf_we    = 1'b0;
        lpf_waddr = N_W'(i_reg);
        lpf_wdata = i_reg;
        lpf_raddr = N_W'(i_reg);
        pl_we     = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                lpf_we    = 1'b1;
                lpf_wdata = '0;
            end
            S_FCHK:
            begin
                lpf_we = (lpf_q_reg == '0);
                pl_we  = (lpf_q_reg == '0) && (cnt_reg < FILL_W'(PRIME_SLOTS));
            end
            S_KCHK:
            begin
                lpf_we    = !kchk_stop;
                lpf_waddr = N_W'(prod_reg[VAL_W-1:0]);
                lpf_wdata = q_reg;
            end
            S_QREAD:
            begin
                lpf_raddr = N_W'(x_reg);
            end
            default:
            begin
                lpf_we = 1'b0;
            end
        endcase
    end

    // least-factor table
    always_ff @(posedge clk)
    begin
        if (lpf_we)
        begin
            lpf_mem[lpf_waddr] <= lpf_wdata;
        end
        lpf_q_reg <= lpf_mem[lpf_raddr];
    end

    // prime list
    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            plist_mem[cnt_reg[SLOT_W-1:0]] <= i_reg;
        end
        pl_q_reg <= plist_mem[k_reg[SLOT_W-1:0]];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= LIM_MAX;
            lim_reg    <= '0;
            built_reg  <= '0;
            ready_reg  <= 1'b0;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            rvalid_reg <= 1'b0;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (cmd.func == FUNC_BUILD)
                        begin
                            lim_reg   <= lim_next;
                            i_reg     <= '0;
                            cnt_reg   <= '0;
                            ready_reg <= 1'b0;
                            state_reg <= S_CLR;
                        end
                        else if (!ready_reg || cmd.value > built_reg)
                        begin
                            result_reg       <= '0;
                            result_reg.error <= 1'b1;
                            result_reg.last  <= 1'b1;
                            rvalid_reg       <= 1'b1;
                        end
                        else if (cmd.value < VAL_W'(2))
                        begin
                            result_reg      <= '0;
                            result_reg.last <= 1'b1;
                            rvalid_reg      <= 1'b1;
                        end
                        else
                        begin
                            x_reg     <= cmd.value;
                            n_reg     <= '0;
                            state_reg <= S_QREAD;
                        end
                    end
                end
                // clear entries 0..limit, i doubles as address
                S_CLR:
                begin
                    if (i_reg == lim_reg)
                    begin
                        if (lim_reg < VAL_W'(2))
                        begin
                            ready_reg              <= 1'b1;
                            built_reg              <= lim_reg;
                            result_reg             <= '0;
                            result_reg.last        <= 1'b1;
                            rvalid_reg             <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= VAL_W'(2);
                            state_reg <= S_FREAD;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_FREAD:
                begin
                    state_reg <= S_FCHK;
                end
                // new prime when entry is still zero
                S_FCHK:
                begin
                    if (lpf_q_reg == '0)
                    begin
                        f_reg <= i_reg;
                        if (cnt_reg < FILL_W'(PRIME_SLOTS))
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        f_reg <= lpf_q_reg;
                    end
                    k_reg     <= '0;
                    state_reg <= S_KREAD;
                end
                S_KREAD:
                begin
                    if (k_reg >= cnt_reg)
                    begin
                        if (i_reg == lim_reg)
                        begin
                            ready_reg              <= 1'b1;
                            built_reg              <= lim_reg;
                            result_reg             <= '0;
                            result_reg.prime_count <= cnt_reg[CNT_W-1:0];
                            result_reg.last        <= 1'b1;
                            rvalid_reg             <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_FREAD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_KMUL;
                    end
                end
                // one multiply per prime tried
                S_KMUL:
                begin
                    q_reg     <= pl_q_reg;
                    prod_reg  <= {{VAL_W{1'b0}}, pl_q_reg} * {{VAL_W{1'b0}}, i_reg};
                    state_reg <= S_KCHK;
                end
                S_KCHK:
                begin
                    if (kchk_stop)
                    begin
                        k_reg <= cnt_reg;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    state_reg <= S_KREAD;
                end
                S_QREAD:
                begin
                    state_reg <= S_QCHK;
                end
                S_QCHK:
                begin
                    if (lpf_q_reg < VAL_W'(2))
                    begin
                        if (n_reg == '0)
                        begin
                            result_reg      <= '0;
                            result_reg.last <= 1'b1;
                            rvalid_reg      <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        p_reg     <= lpf_q_reg;
                        e_reg     <= '0;
                        rem_reg   <= '0;
                        quo_reg   <= x_reg;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                // restoring divider, one quotient bit a cycle
                S_DIV:
                begin
                    rem_reg  <= div_ge ? (div_sh - {1'b0, p_reg}) : div_sh;
                    quo_reg  <= {quo_reg[VAL_W-2:0], div_ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'(VAL_W - 1))
                    begin
                        state_reg <= S_DDONE;
                    end
                end
                S_DDONE:
                begin
                    if (rem_reg == '0)
                    begin
                        x_reg     <= quo_reg;
                        e_reg     <= e_reg + 1'b1;
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        result_reg          <= '0;
                        result_reg.prime    <= p_reg;
                        result_reg.exponent <= e_reg;
                        result_reg.last     <= (x_reg == VAL_W'(1)) ||
                                               (n_reg == FACT_W'(MAX_FACTORS - 1));
                        rvalid_reg          <= 1'b1;
                        n_reg               <= n_reg + 1'b1;
                        if ((x_reg == VAL_W'(1)) || (n_reg == FACT_W'(MAX_FACTORS - 1)))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            quo_reg   <= x_reg;
                            state_reg <= S_QREAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `LSF_ASSERT_NOW(a_last_idle, result_valid && result.last, !busy, "busy after last result")
    `LSF_ASSERT_NOW(a_mid_busy, result_valid && !result.last, busy, "idle before last result")
    `LSF_ASSERT_NOW(a_err_empty, result_valid && result.error, result.prime == '0,
        "error result carries a factor")
    `LSF_ASSERT_NOW(a_exp_set, result_valid && result.prime != '0, result.exponent != '0,
        "factor without exponent")
    `LSF_ASSERT_NEXT(a_busy_after, start && !busy && cmd.func == FUNC_BUILD, busy,
        "build not started")

endmodule

### dv/lpf_sieve_factorizer_tb.sv
// testbench for the least-prime-factor sieve factorizer: directed table, then random traffic
// depends on lsf_pkg and lpf_sieve_factorizer; builds its own prime count and factorization
module lpf_sieve_factorizer_tb;
    import lsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 345;
    localparam int WATCHDOG   = 3000000;

    typedef enum logic { ROW_CFG, ROW_CMD } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [VAL_W-1:0] data;   // limit for cfg rows, value for cmd rows
        func_t            func;
        bit               typed;  // expected result given in the row
        result_t          res;
    } row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    // copy of the block's state
    logic [VAL_W-1:0] limit_reg = 20'hFFFFF;
    logic [VAL_W-1:0] built_lim = '0;
    bit               built = 0;
    logic [CNT_W-1:0] built_count = '0;

    result_t factor_q[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    row_t    rows[$];

    lpf_sieve_factorizer u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #1 clk = ~clk;

    // count of primes up to lim
    function automatic logic [CNT_W-1:0] count_primes(int lim);
        bit composite[];
        int n;
        composite = new[lim + 1];
        n = 0;
        for (int i = 2; i <= lim; i++)
        begin
            if (!composite[i])
            begin
                if (n < PRIME_SLOTS)
                    n++;
                for (int j = 2 * i; j <= lim; j += i)
                    composite[j] = 1;
            end
        end
        return n[CNT_W-1:0];
    endfunction

    // expected results of one transaction, state updated on build
    function automatic void predict_factors(cmd_t c, ref result_t outq[$]);
        result_t r;
        int x;
        int e;
        outq.delete();
        r = '0;
        x = int'(c.value);
        if (func_t'(c.func) == FUNC_BUILD)
        begin
            built_lim   = limit_reg;
            built       = 1;
            built_count = count_primes(int'(limit_reg));
            r.prime_count = built_count;
            r.last = 1;
            outq.insert(outq.size(), r);
            return;
        end
        if (!built || x > built_lim)
        begin
            r.error = 1;
            r.last  = 1;
            outq.insert(outq.size(), r);
            return;
        end
        // trial division gives the same distinct primes in increasing order
        for (int d = 2; d * d <= x && outq.size() < MAX_FACTORS; d++)
        begin
            if (x % d == 0)
            begin
                e = 0;
                while (x % d == 0)
                begin
                    x = x / d;
                    e++;
                end
                r = '0;
                r.prime = VAL_W'(d);
                r.exponent = EXP_W'(e);
                outq.insert(outq.size(), r);
            end
        end
        if (x > 1 && outq.size() < MAX_FACTORS)
        begin
            r = '0;
            r.prime = VAL_W'(x);
            r.exponent = EXP_W'(1);
            outq.insert(outq.size(), r);
        end
        if (outq.size() == 0)
        begin
            r = '0;
            outq.insert(outq.size(), r);
        end
        outq[outq.size() - 1].last = 1;
    endfunction

    // drive one transaction and hold until accepted
    task automatic send_cmd(cmd_t c, bit typed, result_t typed_res);
        result_t exp_q[$];
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_factors(c, exp_q);
        if (typed)
            factor_q.insert(factor_q.size(), typed_res);
        else
            foreach (exp_q[i])
                factor_q.insert(factor_q.size(), exp_q[i]);
    endtask

    // drop start and wait for every expected result
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (factor_q.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_limit(logic [19:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        limit_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_row(row_kind_t k, int d, func_t f, bit t,
                                    int p, int e, int cnt, bit err);
        row_t rw;
        rw.kind = k;
        rw.data = VAL_W'(d);
        rw.func = f;
        rw.typed = t;
        rw.res = '0;
        rw.res.prime = VAL_W'(p);
        rw.res.exponent = EXP_W'(e);
        rw.res.prime_count = CNT_W'(cnt);
        rw.res.error = err;
        rw.res.last = 1;
        rows.insert(rows.size(), rw);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (factor_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: prime=%0d exp=%0d cnt=%0d err=%0b last=%0b",
                             result.prime, result.exponent, result.prime_count,
                             result.error, result.last);
            end
            else
            begin
                want = factor_q.pop_front();
                if (result.prime !== want.prime || result.exponent !== want.exponent ||
                    result.prime_count !== want.prime_count ||
                    result.error !== want.error || result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp prime=%0d e=%0d cnt=%0d err=%0b last=%0b,",
                                  " got prime=%0d e=%0d cnt=%0d err=%0b last=%0b"},
                                 want.prime, want.exponent, want.prime_count, want.error,
                                 want.last, result.prime, result.exponent,
                                 result.prime_count, result.error, result.last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction or result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        cmd_t c;
        int   gap_pct;
        int   sel;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        add_row(ROW_CMD, 5, FUNC_FACTORIZE, 1, 0, 0, 0, 1);      // query before build
        add_row(ROW_CMD, 0, FUNC_FACTORIZE, 1, 0, 0, 0, 1);
        add_row(ROW_CFG, 0, FUNC_BUILD, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, FUNC_BUILD, 1, 0, 0, 0, 0);          // limit 0: no primes
        add_row(ROW_CMD, 0, FUNC_FACTORIZE, 1, 0, 0, 0, 0);
        add_row(ROW_CMD, 1, FUNC_FACTORIZE, 1, 0, 0, 0, 1);
        add_row(ROW_CFG, 2, FUNC_BUILD, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 20'hFFFFF, FUNC_BUILD, 1, 0, 0, 1, 0);  // limit 2: one prime
        add_row(ROW_CMD, 2, FUNC_FACTORIZE, 1, 2, 1, 0, 0);
        add_row(ROW_CMD, 3, FUNC_FACTORIZE, 1, 0, 0, 0, 1);
        add_row(ROW_CFG, 4096, FUNC_BUILD, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, FUNC_BUILD, 1, 0, 0, 564, 0);
        add_row(ROW_CMD, 4096, FUNC_FACTORIZE, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 4095, FUNC_FACTORIZE, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 2310, FUNC_FACTORIZE, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 4093, FUNC_FACTORIZE, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 1, FUNC_FACTORIZE, 1, 0, 0, 0, 0);
        add_row(ROW_CMD, 4097, FUNC_FACTORIZE, 1, 0, 0, 0, 1);
        add_row(ROW_CFG, 20'hFFFFF, FUNC_BUILD, 0, 0, 0, 0, 0);  // register changed, not built
        add_row(ROW_CMD, 20'hFFFFF, FUNC_FACTORIZE, 1, 0, 0, 0, 1);
        add_row(ROW_CMD, 3072, FUNC_FACTORIZE, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, 3000, FUNC_BUILD, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, FUNC_BUILD, 0, 0, 0, 0, 0);
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_limit(rows[i].data);
            else
            begin
                c.func  = rows[i].func;
                c.value = rows[i].data;
                send_cmd(c, rows[i].typed, rows[i].res);
            end
        end

        // random traffic in idle phases: none, 69%, none (results never stall), 31%
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case (n * 4 / RAND_ITEMS)
                1:       gap_pct = 69;
                3:       gap_pct = 31;
                default: gap_pct = 0;
            endcase
            if (n == RAND_ITEMS / 2)
                drain();
            sel = $urandom_range(0, 99);
            c.value = VAL_W'($urandom_range(0, 20'hFFFFF));
            if (sel < 5)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_limit(VAL_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1)
                                                               : $urandom_range(2, 3000)));
                c.func = FUNC_BUILD;
            end
            else
            begin
                c.func = FUNC_FACTORIZE;
                if (sel < 75)
                    c.value = VAL_W'($urandom_range(0, built_lim));
                else if (sel < 85)
                    c.value = VAL_W'($urandom_range(0, 3));
            end
            send_cmd(c, 0, '0);
            // sender stays idle each cycle with probability gap_pct
            while ($urandom_range(0, 99) < gap_pct)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && factor_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/lsf_pkg.sv
src/lpf_sieve_factorizer.sv
dv/lpf_sieve_factorizer_tb.sv
